/* rtl/lpfmf_pkg.sv */
// lpfmf_pkg: shared constants and types for the length-prefixed frame mac filter
// used by lpfmf_parser, lpfmf_fifo and length_prefixed_frame_mac_filter
package lpfmf_pkg;

  localparam int unsigned BufferBytes = 1024;
  localparam int unsigned MinKept     = 12;
  localparam int unsigned AddrBytes   = 6;
  localparam int unsigned BurstMax    = AddrBytes + 1;
  localparam int unsigned FifoDepth   = 16;
  localparam int unsigned PtrW        = $clog2(FifoDepth);
  localparam int unsigned CntW        = $clog2(FifoDepth + 1);
  localparam int unsigned PushW       = $clog2(BurstMax + 1);

  localparam logic [47:0] BroadcastAddr = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] frame_byte;
  } entry_t;

  typedef struct packed {
    logic [PushW-1:0]            cnt;
    entry_t [BurstMax-1:0]       ent;
  } push_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            space_ok;
  } fifo_status_t;

endpackage

/* rtl/length_prefixed_frame_mac_filter.sv */
// length_prefixed_frame_mac_filter: top level, input register, config register
// depends on lpfmf_pkg, lpfmf_parser, lpfmf_fifo
//
// usage
// - input channel: in_valid_i / in_stall_o carry rx_byte_i, one stream byte per request;
//   each frame is a 16-bit big-endian length followed by that many body bytes
// - output channel: out_valid_o / out_stall_i carry frame_byte_o and frame_end_o for
//   frames of at least 12 kept bytes whose destination is the station or broadcast
// - config channel: cfg_valid_i / cfg_ready_o write the 48-bit station address
//   from cfg_data_i; ready is always high, write only while the block is idle
// - path: with the queue empty, a passed body byte passes the input register and
//   the queue memory to the output; the seventh body byte follows the six held bytes
// - throughput: one input byte per cycle while the queue has room; a passing frame's
//   seventh body byte releases seven results; the 16-entry queue drains one per cycle
// - the input stalls only when the queue holds more than nine results, so a
//   receiver taking one result per cycle never slows the input
// - out_stall_i holds the head result in place; backpressure reaches the input
//   once the queue fills up
// - reset clears framing state, the queue and the station address (to zero)
module length_prefixed_frame_mac_filter
  import lpfmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic [47:0]  station_q;
  logic         step;
  push_t        push;
  entry_t       head;
  fifo_status_t status;

  assign step        = in_valid_q && status.space_ok;
  assign in_stall_o  = in_valid_q && !status.space_ok;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      station_q  <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        station_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lpfmf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .station_i (station_q),
    .push_o    (push)
  );

  lpfmf_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (!out_stall_i),
    .head_o   (head),
    .status_o (status)
  );

  assign out_valid_o  = (status.count != '0);
  assign frame_byte_o = head.frame_byte;
  assign frame_end_o  = head.frame_end;

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.count <= CntW'(FifoDepth))
    else $error("result queue over capacity");

  a_push_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == '0) || (push.cnt == PushW'(1)) || (push.cnt == PushW'(BurstMax)))
    else $error("illegal burst size");

  a_push_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != '0) |-> (step && status.space_ok))
    else $error("results pushed without a consumed byte");

  a_no_overflow_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != '0) |=> (status.count <= CntW'(FifoDepth)))
    else $error("burst overran the result queue");
`endif

endmodule

/* rtl/lpfmf_parser.sv */
// lpfmf_parser: frame length tracking, header hold and destination filter
// depends on lpfmf_pkg
module lpfmf_parser
  import lpfmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [47:0] station_i,
  output push_t       push_o
);

  localparam logic [15:0] BufLen  = 16'(BufferBytes);
  localparam logic [15:0] MinLen  = 16'(MinKept);
  localparam logic [15:0] AddrPos = 16'(AddrBytes);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] pos_q, pos_d;
  logic        acc_q, acc_d;
  logic [7:0]  hdr_q [AddrBytes];

  logic [15:0] kept;
  logic [16:0] pos_next;
  logic [47:0] held_addr;
  logic        last;
  logic        hdr_we;
  logic        pass;

  assign kept     = (flen_q < BufLen) ? flen_q : BufLen;
  assign pos_next = {1'b0, pos_q} + 17'd1;
  assign last     = (pos_next == {1'b0, kept});
  assign held_addr = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5]};
  assign pass     = (kept >= MinLen) &&
                    ((held_addr == station_i) || (held_addr == BroadcastAddr));

  always_comb begin
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    flen_d   = flen_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    hdr_we   = 1'b0;
    push_o   = '0;
    case (phase_q)
      PH_LEN_LO: begin
        flen_d  = {len_hi_q, byte_i};
        pos_d   = '0;
        acc_d   = 1'b0;
        phase_d = ({len_hi_q, byte_i} == 16'd0) ? PH_LEN_HI : PH_BODY;
      end
      PH_BODY: begin
        if (pos_q < kept) begin
          if (pos_q < AddrPos) begin
            hdr_we = 1'b1;
          end else if (pos_q == AddrPos) begin
            acc_d = pass;
            if (pass) begin
              push_o.cnt = PushW'(BurstMax);
              for (int k = 0; k < AddrBytes; k++) begin
                push_o.ent[k] = '{frame_end: 1'b0, frame_byte: hdr_q[k]};
              end
              push_o.ent[AddrBytes] = '{frame_end: last, frame_byte: byte_i};
            end
          end else if (acc_q) begin
            push_o.cnt    = PushW'(1);
            push_o.ent[0] = '{frame_end: last, frame_byte: byte_i};
          end
        end
        pos_d = pos_next[15:0];
        if (pos_next >= {1'b0, flen_q}) begin
          phase_d = PH_LEN_HI;
          acc_d   = 1'b0;
        end
      end
      default: begin
        len_hi_d = byte_i;
        phase_d  = PH_LEN_LO;
      end
    endcase
    if (!step_i) begin
      push_o.cnt = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN_HI;
      len_hi_q <= '0;
      flen_q   <= '0;
      pos_q    <= '0;
      acc_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      flen_q   <= flen_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && hdr_we) begin
      hdr_q[pos_q[2:0]] <= byte_i;
    end
  end

endmodule

/* rtl/lpfmf_fifo.sv */
// lpfmf_fifo: result queue taking a burst of up to seven entries per cycle
// depends on lpfmf_pkg
module lpfmf_fifo
  import lpfmf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  input  logic         pop_i,
  output entry_t       head_o,
  output fifo_status_t status_o
);

  entry_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign count_d = count_q + CntW'(push_i.cnt) - CntW'(do_pop);

  assign head_o            = mem_q[rd_ptr_q];
  assign status_o.count    = count_q;
  assign status_o.space_ok = (count_q <= CntW'(FifoDepth - BurstMax));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + PtrW'(do_pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BurstMax; k++) begin
      if (PushW'(k) < push_i.cnt) begin
        mem_q[wr_ptr_q + PtrW'(k)] <= push_i.ent[k];
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench for length_prefixed_frame_mac_filter: drives framed byte streams and
// checks every passed frame byte against a tracker class; depends on lpfmf_pkg
class mac_filter_tracker;
  bit [47:0]               station;
  lpfmf_pkg::phase_e       phase;
  bit [7:0]                len_hi;
  bit [15:0]               frame_len;
  int unsigned             body_pos;
  bit [7:0]                header [lpfmf_pkg::AddrBytes];
  bit                      passing;
  lpfmf_pkg::entry_t       due_bytes [$];
  int unsigned             mismatches;

  function new();
    station    = '0;
    phase      = lpfmf_pkg::PH_LEN_HI;
    len_hi     = '0;
    frame_len  = '0;
    body_pos   = 0;
    passing    = 1'b0;
    mismatches = 0;
  endfunction

  function void queue_result(bit [7:0] data, bit last);
    lpfmf_pkg::entry_t e;
    e.frame_byte = data;
    e.frame_end  = last;
    due_bytes.push_back(e);
  endfunction

  // one accepted stream byte
  function void take_rx_byte(bit [7:0] data);
    int unsigned kept;
    bit [47:0]   dest;
    case (phase)
      lpfmf_pkg::PH_LEN_LO: begin
        frame_len = {len_hi, data};
        body_pos  = 0;
        passing   = 1'b0;
        phase     = (frame_len == 0) ? lpfmf_pkg::PH_LEN_HI : lpfmf_pkg::PH_BODY;
      end
      lpfmf_pkg::PH_BODY: begin
        kept = (frame_len < lpfmf_pkg::BufferBytes) ? frame_len : lpfmf_pkg::BufferBytes;
        if (body_pos < kept) begin
          if (body_pos < lpfmf_pkg::AddrBytes) begin
            header[body_pos] = data;
          end else if (body_pos == lpfmf_pkg::AddrBytes) begin
            dest = {header[0], header[1], header[2], header[3], header[4], header[5]};
            passing = (kept >= lpfmf_pkg::MinKept) &&
                      (dest == station || dest == lpfmf_pkg::BroadcastAddr);
            if (passing) begin
              foreach (header[i]) queue_result(header[i], 1'b0);
              queue_result(data, body_pos + 1 == kept);
            end
          end else if (passing) begin
            queue_result(data, body_pos + 1 == kept);
          end
        end
        body_pos++;
        if (body_pos >= frame_len) begin
          phase   = lpfmf_pkg::PH_LEN_HI;
          passing = 1'b0;
        end
      end
      default: begin
        len_hi = data;
        phase  = lpfmf_pkg::PH_LEN_LO;
      end
    endcase
  endfunction

  function void check_frame_byte(logic [7:0] data, logic last);
    lpfmf_pkg::entry_t want;
    if (due_bytes.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte %02h end %0b",
               $time, data, last);
      mismatches++;
      return;
    end
    want = due_bytes.pop_front();
    if (data !== want.frame_byte) begin
      $display("%0t: frame_byte expected %02h actual %02h", $time, want.frame_byte, data);
      mismatches++;
    end
    if (last !== want.frame_end) begin
      $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, last);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return due_bytes.size();
  endfunction
endclass

module testbench;
  import lpfmf_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_byte_o;
  logic        frame_end_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [47:0] cfg_data_i;

  mac_filter_tracker tracker;
  bit                hold_req;
  bit                in_steady;
  int unsigned       cycle_count;
  int unsigned       hold_left;
  int unsigned       run_left;
  bit                stalling;

  length_prefixed_frame_mac_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_byte_o(frame_byte_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned free_run();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 6);
    return $urandom_range(20, 120);
  endfunction

  function automatic bit [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 25) return 16'($urandom_range(1, 11));
    if (r < 95) return 16'($urandom_range(12, 40));
    return 16'($urandom_range(41, 200));
  endfunction

  function automatic bit [47:0] pick_dest();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return tracker.station;
    if (r < 70) return BroadcastAddr;
    if (r < 85) return tracker.station ^ (48'h1 << $urandom_range(0, 47));
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_byte(input bit [7:0] data);
    int unsigned gap;
    gap = in_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_rx_byte(data);
  endtask

  task automatic send_frame(input bit [15:0] len, input bit [47:0] dest);
    int unsigned i;
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (i = 0; i < len; i++) begin
      if (i < AddrBytes) send_byte(dest[8*(AddrBytes-1-i) +: 8]);
      else send_byte(8'($urandom));
    end
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned sent;
    bit [15:0]   len;
    sent = 0;
    while (sent < budget) begin
      len       = pick_len();
      in_steady = ($urandom_range(0, 3) == 0);
      send_frame(len, pick_dest());
      sent += len + 2;
    end
    in_steady = 1'b0;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // only between frames, once every passed byte has come out
  task automatic write_station(input bit [47:0] addr);
    release_input();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.station = addr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    run_left    = 0;
    stalling    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HoldCycles;
        stalling    = 1'b1;
        run_left    = 0;
        out_stall_i <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stalling    = !stalling;
        run_left    = stalling ? pick_gap() : free_run();
        out_stall_i <= stalling;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_frame_byte(frame_byte_o, frame_end_o);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit [47:0] addr;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    in_steady   = 1'b0;
    tracker     = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // station address still at its reset value
    send_frame(16'd0, 48'h0);
    send_frame(16'd11, BroadcastAddr);
    send_frame(16'd12, 48'h0);
    run_frames(120);

    write_station(BroadcastAddr);
    hold_req  = 1'b1;
    in_steady = 1'b1;
    repeat (3) send_frame(16'd12, BroadcastAddr);
    send_frame(16'd48, BroadcastAddr);
    in_steady = 1'b0;
    run_frames(120);

    addr = {16'($urandom), 32'($urandom)};
    write_station(addr);
    send_frame(16'd1030, addr);
    run_frames(130);

    write_station(48'h0);
    run_frames(130);

    release_input();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
